FILE: rtl/core/ssmb_pkg.sv
`default_nettype none

package ssmb_pkg;

  // Bus geometry
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned KeyW     = 7;
  localparam int unsigned MemDepth = 65536;

  // Request codes
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KEY   = 2'd2,
    REQ_LOAD  = 2'd3
  } req_e;

  // Address map: the I/O window and the ROM region are whole 4K pages
  localparam logic [3:0]        IoPage     = 4'hC;
  localparam logic [3:0]        RomPage    = 4'hD;
  localparam logic [AddrW-1:0]  KbdData    = 16'hC000;
  localparam logic [AddrW-1:0]  KbdStrobe  = 16'hC010;
  // 0xC050-0xC057 share everything above the low three bits
  localparam logic [AddrW-4:0]  SwBlock    = 13'h180A;

  // Soft switch offsets inside the switch block
  localparam logic [2:0] SwTextClr  = 3'd0;
  localparam logic [2:0] SwTextSet  = 3'd1;
  localparam logic [2:0] SwMixedClr = 3'd2;
  localparam logic [2:0] SwMixedSet = 3'd3;
  localparam logic [2:0] SwLores    = 3'd6;
  localparam logic [2:0] SwHires    = 3'd7;

  // Screen area preset after reset: 0x0400-0x07FF, i.e. address bits [15:10] == 1
  localparam logic [5:0]       ScreenBlk  = 6'b000001;
  localparam logic [DataW-1:0] ScreenFill = 8'hA0;

  // Display and keyboard flags
  typedef struct packed {
    logic text;
    logic mixed;
    logic lores;
    logic hires;
    logic key_waiting;
  } sw_t;

  // Store write from the reset sweep
  typedef struct packed {
    logic             busy;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } clr_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssmb_if.sv
`default_nettype none

// Bus request channel
interface ssmb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [15:0] address;
  logic [7:0] write_data;
  logic [6:0] key_code;

  modport source (output valid, output req_type, output address, output write_data,
                  output key_code, input ready);
  modport sink   (input valid, input req_type, input address, input write_data,
                  input key_code, output ready);
endinterface

// Bus response channel
interface ssmb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       text_on;
  logic       mixed_on;
  logic       low_res;
  logic       hires_on;
  logic       key_waiting;

  modport source (output valid, output read_data, output text_on, output mixed_on,
                  output low_res, output hires_on, output key_waiting, input ready);
  modport sink   (input valid, input read_data, input text_on, input mixed_on,
                  input low_res, input hires_on, input key_waiting, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ssmb_ram.sv
`default_nettype none

module ssmb_ram #(
  parameter int unsigned Width = ssmb_pkg::DataW,
  parameter int unsigned Depth = ssmb_pkg::MemDepth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Single port, registered read; read data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/ssmb_clr.sv
`default_nettype none

module ssmb_clr (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  output ssmb_pkg::clr_t clr_o
);

  logic [ssmb_pkg::AddrW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;

  // Walk every address once after reset
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Screen area gets the blank fill, the rest zero
  always_comb begin
    clr_o.busy = busy_q;
    clr_o.addr = cnt_q;
    clr_o.data = (cnt_q[ssmb_pkg::AddrW-1:10] == ssmb_pkg::ScreenBlk) ?
                 ssmb_pkg::ScreenFill : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssmb_io.sv
`default_nettype none

module ssmb_io (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       acc_i,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [ssmb_pkg::AddrW-1:0] addr_i,
  input  wire logic [ssmb_pkg::KeyW-1:0]  key_code_i,
  output ssmb_pkg::sw_t                   sw_o,
  output logic      [ssmb_pkg::DataW-1:0] io_rdata_o
);

  ssmb_pkg::sw_t              sw_q, sw_d;
  logic [ssmb_pkg::KeyW-1:0]  key_q, key_d;
  logic                       io_win;
  logic                       bus_acc;
  logic                       touch;

  assign io_win  = (addr_i[ssmb_pkg::AddrW-1:12] == ssmb_pkg::IoPage);
  assign bus_acc = (req_type_i == ssmb_pkg::REQ_READ) || (req_type_i == ssmb_pkg::REQ_WRITE);
  assign touch   = acc_i && bus_acc && io_win;

  // Keyboard latch and soft switch updates
  always_comb begin
    sw_d  = sw_q;
    key_d = key_q;
    if (acc_i && (req_type_i == ssmb_pkg::REQ_KEY)) begin
      key_d            = key_code_i;
      sw_d.key_waiting = 1'b1;
    end
    if (touch && (addr_i == ssmb_pkg::KbdStrobe)) begin
      sw_d.key_waiting = 1'b0;
    end
    if (touch && (addr_i[ssmb_pkg::AddrW-1:3] == ssmb_pkg::SwBlock)) begin
      unique case (addr_i[2:0])
        ssmb_pkg::SwTextClr:  sw_d.text  = 1'b0;
        ssmb_pkg::SwTextSet:  sw_d.text  = 1'b1;
        ssmb_pkg::SwMixedClr: sw_d.mixed = 1'b0;
        ssmb_pkg::SwMixedSet: sw_d.mixed = 1'b1;
        ssmb_pkg::SwLores: begin
          sw_d.lores = 1'b1;
          sw_d.hires = 1'b0;
        end
        ssmb_pkg::SwHires: begin
          sw_d.lores = 1'b0;
          sw_d.hires = 1'b1;
        end
        default: ;  // page switches
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= '{text: 1'b1, mixed: 1'b0, lores: 1'b0, hires: 1'b0, key_waiting: 1'b0};
      key_q <= '0;
    end else begin
      sw_q  <= sw_d;
      key_q <= key_d;
    end
  end

  // Keyboard data read; every other window read returns zero
  assign io_rdata_o = ((req_type_i == ssmb_pkg::REQ_READ) && (addr_i == ssmb_pkg::KbdData) &&
                       sw_q.key_waiting) ? {1'b1, key_q} : '0;
  assign sw_o = sw_q;

endmodule

`default_nettype wire

FILE: rtl/core/soft_switch_memory_bus_top.sv
// Channel  Dir  Payload                                              Transfer
// req_i    in   req_type, address, write_data, key_code              valid & ready
// rsp_o    out  read_data, text_on, mixed_on, low_res, hires_on,
//               key_waiting                                          valid & ready
//
// After reset a clearing pass writes the whole 64K store, one byte a cycle,
// during which req_i.ready stays low.
// Then one request a cycle while the response is not stalled; its response shows in the
// cycle after the transfer, as the store's read port is registered.
// The response sits in an output register; while it is stalled no new request is taken.
`default_nettype none

module soft_switch_memory_bus_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssmb_req_if.sink   req_i,
  ssmb_rsp_if.source rsp_o
);

  ssmb_pkg::clr_t             clr;
  ssmb_pkg::sw_t              sw;
  logic [ssmb_pkg::DataW-1:0] io_rdata;
  logic [ssmb_pkg::DataW-1:0] ram_rdata;
  logic                       in_acc;
  logic                       io_win;
  logic                       rom;
  logic                       mem_rd;
  logic                       mem_wr;
  logic                       out_valid_q;
  logic                       use_mem_q;
  logic [ssmb_pkg::DataW-1:0] io_data_q;

  // Request handshake
  assign req_i.ready = !clr.busy && (!out_valid_q || rsp_o.ready);
  assign in_acc      = req_i.valid && req_i.ready;

  // Address decode
  assign io_win = (req_i.address[ssmb_pkg::AddrW-1:12] == ssmb_pkg::IoPage);
  assign rom    = (req_i.address[ssmb_pkg::AddrW-1:12] >= ssmb_pkg::RomPage);
  assign mem_rd = in_acc && (req_i.req_type == ssmb_pkg::REQ_READ) && !io_win;
  assign mem_wr = in_acc && !io_win &&
                  (((req_i.req_type == ssmb_pkg::REQ_WRITE) && !rom) ||
                   (req_i.req_type == ssmb_pkg::REQ_LOAD));

  ssmb_clr u_clr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // Main store; the sweep owns the port until it finishes
  ssmb_ram #(
    .Width (ssmb_pkg::DataW),
    .Depth (ssmb_pkg::MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (clr.busy || mem_rd || mem_wr),
    .we_i    (clr.busy || mem_wr),
    .addr_i  (clr.busy ? clr.addr : req_i.address),
    .wdata_i (clr.busy ? clr.data : req_i.write_data),
    .rdata_o (ram_rdata)
  );

  ssmb_io u_io (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .req_type_i (req_i.req_type),
    .addr_i     (req_i.address),
    .key_code_i (req_i.key_code),
    .sw_o       (sw),
    .io_rdata_o (io_rdata)
  );

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Read data source select, captured at the transfer
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      use_mem_q <= mem_rd;
      io_data_q <= io_rdata;
    end
  end

  // Flags change only on a transfer, which also replaces the response
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = use_mem_q ? ram_rdata : io_data_q;
  assign rsp_o.text_on     = sw.text;
  assign rsp_o.mixed_on    = sw.mixed;
  assign rsp_o.low_res     = sw.lores;
  assign rsp_o.hires_on    = sw.hires;
  assign rsp_o.key_waiting = sw.key_waiting;

endmodule

`default_nettype wire

FILE: rtl/core/ssmb_chk.sv
`default_nettype none

module ssmb_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic [1:0]  req_type_i,
  input wire logic [15:0] address_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [7:0]  read_data_i,
  input wire logic        key_waiting_i
);

  logic req_xfer;
  assign req_xfer = req_valid_i && req_ready_i;

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_data_i))
    else $error("stalled response changed");

  // No request is taken while the response is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_xfer)
    else $error("request taken over a stalled response");

  // A key press shows in the very next response
  a_key_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && (req_type_i == ssmb_pkg::REQ_KEY) |=> rsp_valid_i && key_waiting_i)
    else $error("key press did not set the ready flag");

  // Any read or write of the strobe clears the ready flag
  a_strobe_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && ((req_type_i == ssmb_pkg::REQ_READ) || (req_type_i == ssmb_pkg::REQ_WRITE)) &&
    (address_i == ssmb_pkg::KbdStrobe)
    |=> rsp_valid_i && !key_waiting_i)
    else $error("strobe did not clear the ready flag");

  // Window reads other than keyboard data return zero
  a_io_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer && (req_type_i == ssmb_pkg::REQ_READ) && (address_i[15:12] == ssmb_pkg::IoPage) &&
    (address_i != ssmb_pkg::KbdData)
    |=> rsp_valid_i && (read_data_i == 8'h00))
    else $error("window read returned nonzero");

endmodule

bind soft_switch_memory_bus_top ssmb_chk u_ssmb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_type_i    (req_i.req_type),
  .address_i     (req_i.address),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_data_i   (rsp_o.read_data),
  .key_waiting_i (rsp_o.key_waiting)
);

`default_nettype wire

FILE: sim/soft_switch_memory_bus_top_tb.sv
`timescale 1ns / 100ps

module soft_switch_memory_bus_top_tb;
  import ssmb_pkg::*;

  // One bus request plus the idle cycles the driver inserts after it
  typedef struct {
    req_e             kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
    logic [KeyW-1:0]  key;
    int               gap_after;
  } bus_req_t;

  // Byte read plus the display and keyboard flags after the access
  typedef struct packed {
    logic [DataW-1:0] read_data;
    sw_t              flags;
  } bus_reply_t;

  localparam int NumRandom = 1120;
  localparam int DrainCycles = 8;

  logic clk_i;
  logic rst_ni;

  ssmb_req_if req_if ();
  ssmb_rsp_if rsp_if ();

  soft_switch_memory_bus_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the bus state
  logic [DataW-1:0] shadow_store [MemDepth];
  logic [KeyW-1:0]  shadow_key;
  sw_t              shadow_sw;

  bus_req_t   pending_reqs [$];
  bus_reply_t bus_replies  [$];
  logic [AddrW-1:0] hot_addr [16];

  int error_count = 0;
  int reply_count;
  int hold_left;
  int next_hold_at;
  int gap_left;
  int stall_left;
  int mon_cycle;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Side effects of any read or write in the I/O page
  task automatic io_touch(input logic [AddrW-1:0] addr);
    if (addr == KbdStrobe) begin
      shadow_sw.key_waiting = 1'b0;
    end else if (addr[AddrW-1:3] == SwBlock) begin
      case (addr[2:0])
        SwTextClr:  shadow_sw.text = 1'b0;
        SwTextSet:  shadow_sw.text = 1'b1;
        SwMixedClr: shadow_sw.mixed = 1'b0;
        SwMixedSet: shadow_sw.mixed = 1'b1;
        SwLores: begin
          shadow_sw.lores = 1'b1;
          shadow_sw.hires = 1'b0;
        end
        SwHires: begin
          shadow_sw.lores = 1'b0;
          shadow_sw.hires = 1'b1;
        end
        default: ;
      endcase
    end
  endtask

  // Apply one request to the shadow state and queue the reply it should give
  task automatic apply_bus_request(input req_e kind, input logic [AddrW-1:0] addr,
                                   input logic [DataW-1:0] wdata,
                                   input logic [KeyW-1:0] key);
    logic       in_io;
    bus_reply_t reply;
    in_io = (addr[AddrW-1:12] == IoPage);
    reply.read_data = '0;
    case (kind)
      REQ_READ: begin
        if (!in_io) begin
          reply.read_data = shadow_store[addr];
        end else if (addr == KbdData) begin
          reply.read_data = shadow_sw.key_waiting ? {1'b1, shadow_key} : '0;
        end else begin
          io_touch(addr);
        end
      end
      REQ_WRITE: begin
        if (in_io) io_touch(addr);
        else if (addr[AddrW-1:12] < RomPage) shadow_store[addr] = wdata;
      end
      REQ_KEY: begin
        shadow_key = key;
        shadow_sw.key_waiting = 1'b1;
      end
      default: begin
        // image load ignores ROM protection but not the I/O page
        if (!in_io) shadow_store[addr] = wdata;
      end
    endcase
    reply.flags = shadow_sw;
    bus_replies.push_back(reply);
  endtask

  task automatic add_req(input req_e kind, input logic [AddrW-1:0] addr,
                         input logic [DataW-1:0] wdata, input logic [KeyW-1:0] key,
                         input int gap);
    bus_req_t item;
    item.kind = kind;
    item.addr = addr;
    item.wdata = wdata;
    item.key = key;
    item.gap_after = gap;
    pending_reqs.push_back(item);
  endtask

  // Directed request with random filler in the unused fields
  task automatic add_directed(input req_e kind, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] wdata, input logic [KeyW-1:0] key);
    add_req(kind, addr, wdata, key, pick_gap());
  endtask

  // Address mix: I/O decode, screen, ROM, a small reused pool and the full range
  function automatic logic [AddrW-1:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return AddrW'($urandom);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return KbdData;
        1: return KbdStrobe;
        2: return {SwBlock, 3'($urandom)};
        default: return {IoPage, 12'($urandom)};
      endcase
    end
    if (r < 60) return hot_addr[$urandom_range(0, 15)];
    if (r < 72) return AddrW'($urandom_range(16'h0400, 16'h07FF));
    if (r < 86) return AddrW'($urandom_range(16'hD000, 16'hFFFF));
    return AddrW'($urandom_range(16'h0000, 16'hBFFF));
  endfunction

  function automatic req_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REQ_READ;
    if (r < 70) return REQ_WRITE;
    if (r < 82) return REQ_KEY;
    return REQ_LOAD;
  endfunction

  // Compare one reply transfer against the oldest expectation
  task automatic check_reply();
    bus_reply_t exp_reply;
    if (bus_replies.size() == 0) begin
      $error("reply transfer with nothing expected");
      error_count++;
      return;
    end
    exp_reply = bus_replies.pop_front();
    if (rsp_if.read_data !== exp_reply.read_data) begin
      $error("read_data: expected %0h, got %0h", exp_reply.read_data, rsp_if.read_data);
      error_count++;
    end
    if (rsp_if.text_on !== exp_reply.flags.text) begin
      $error("text_on: expected %0b, got %0b", exp_reply.flags.text, rsp_if.text_on);
      error_count++;
    end
    if (rsp_if.mixed_on !== exp_reply.flags.mixed) begin
      $error("mixed_on: expected %0b, got %0b", exp_reply.flags.mixed, rsp_if.mixed_on);
      error_count++;
    end
    if (rsp_if.low_res !== exp_reply.flags.lores) begin
      $error("low_res: expected %0b, got %0b", exp_reply.flags.lores, rsp_if.low_res);
      error_count++;
    end
    if (rsp_if.hires_on !== exp_reply.flags.hires) begin
      $error("hires_on: expected %0b, got %0b", exp_reply.flags.hires, rsp_if.hires_on);
      error_count++;
    end
    if (rsp_if.key_waiting !== exp_reply.flags.key_waiting) begin
      $error("key_waiting: expected %0b, got %0b", exp_reply.flags.key_waiting,
             rsp_if.key_waiting);
      error_count++;
    end
  endtask

  // Request driver: presents queued requests, predicts each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_READ;
      req_if.address    <= '0;
      req_if.write_data <= '0;
      req_if.key_code   <= '0;
      gap_left = 0;
      // post-reset store contents: screen area filled, rest zero
      for (int i = 0; i < MemDepth; i++) begin
        shadow_store[i] = (i[15:10] == ScreenBlk) ? ScreenFill : '0;
      end
      shadow_key = '0;
      shadow_sw  = '{text: 1'b1, default: 1'b0};
    end else if (!req_if.valid || req_if.ready) begin
      bus_req_t nxt;
      if (req_if.valid) begin
        apply_bus_request(req_e'(req_if.req_type), req_if.address, req_if.write_data,
                          req_if.key_code);
      end
      // idle gaps are skipped while the reply side is held off, to fill the block
      if (gap_left > 0 && hold_left == 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_if.valid      <= 1'b1;
        req_if.req_type   <= nxt.kind;
        req_if.address    <= nxt.addr;
        req_if.write_data <= nxt.wdata;
        req_if.key_code   <= nxt.key;
        gap_left = nxt.gap_after;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Long hold-off on the reply side, at reply 150 and every 500 replies after
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      next_hold_at = 150;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (reply_count >= next_hold_at) begin
      hold_left <= 90;
      next_hold_at += 500;
    end
  end

  // Reply monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      reply_count  <= 0;
      stall_left = 0;
      mon_cycle  = 0;
    end else begin
      mon_cycle++;
      if (rsp_if.valid && rsp_if.ready) begin
        check_reply();
        reply_count <= reply_count + 1;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        // one window in every four of the monitor's cycle count runs without random stalls
        if ((mon_cycle / 300) % 4 != 1 && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int made;
    req_e kind;
    logic [AddrW-1:0] a;

    rst_ni = 1'b0;

    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: hot_addr[i] = AddrW'($urandom_range(16'h0000, 16'h00FF));
        1: hot_addr[i] = AddrW'($urandom_range(16'h0400, 16'h07FF));
        2: hot_addr[i] = AddrW'($urandom_range(16'hD000, 16'hFFFF));
        default: hot_addr[i] = AddrW'($urandom_range(16'h8000, 16'hBFFF));
      endcase
    end

    // Directed: screen preset, keyboard latch, every switch, ROM and load rules
    add_directed(REQ_READ, 16'h0400, $urandom, $urandom);
    add_directed(REQ_READ, 16'h07FF, $urandom, $urandom);
    add_directed(REQ_READ, 16'h03FF, $urandom, $urandom);
    add_directed(REQ_READ, KbdData, $urandom, $urandom);
    add_directed(REQ_KEY, $urandom, $urandom, 7'h00);
    add_directed(REQ_KEY, $urandom, $urandom, 7'h7F);
    add_directed(REQ_READ, KbdData, $urandom, $urandom);
    add_directed(REQ_WRITE, KbdData, 8'hFF, $urandom);
    add_directed(REQ_READ, KbdData, $urandom, $urandom);
    add_directed(REQ_READ, KbdStrobe, $urandom, $urandom);
    add_directed(REQ_READ, KbdData, $urandom, $urandom);
    add_directed(REQ_KEY, $urandom, $urandom, 7'h2A);
    add_directed(REQ_WRITE, KbdStrobe, $urandom, $urandom);
    add_directed(REQ_WRITE, {SwBlock, SwTextClr}, $urandom, $urandom);
    add_directed(REQ_READ, {SwBlock, SwMixedSet}, $urandom, $urandom);
    add_directed(REQ_WRITE, {SwBlock, SwLores}, $urandom, $urandom);
    add_directed(REQ_READ, {SwBlock, SwHires}, $urandom, $urandom);
    add_directed(REQ_READ, {SwBlock, 3'd4}, $urandom, $urandom);
    add_directed(REQ_WRITE, {SwBlock, 3'd5}, $urandom, $urandom);
    add_directed(REQ_READ, {SwBlock, SwMixedClr}, $urandom, $urandom);
    add_directed(REQ_WRITE, {SwBlock, SwTextSet}, $urandom, $urandom);
    add_directed(REQ_READ, 16'hCFFF, $urandom, $urandom);
    add_directed(REQ_LOAD, {SwBlock, SwTextClr}, 8'h00, $urandom);
    add_directed(REQ_WRITE, 16'hFFFF, 8'hAA, $urandom);
    add_directed(REQ_READ, 16'hFFFF, $urandom, $urandom);
    add_directed(REQ_LOAD, 16'hD000, 8'h55, $urandom);
    add_directed(REQ_READ, 16'hD000, $urandom, $urandom);
    add_directed(REQ_WRITE, 16'h0000, 8'hFF, $urandom);
    add_directed(REQ_READ, 16'h0000, $urandom, $urandom);

    // Random: mostly independent accesses, some keyboard handshake sequences
    made = 0;
    while (made < NumRandom) begin
      if ($urandom_range(0, 9) == 0) begin
        add_req(REQ_KEY, $urandom, $urandom, $urandom, pick_gap());
        add_req(REQ_READ, KbdData, $urandom, $urandom, pick_gap());
        add_req(req_e'($urandom_range(0, 1)), KbdStrobe, $urandom, $urandom, pick_gap());
        add_req(REQ_READ, KbdData, $urandom, $urandom, pick_gap());
        made += 4;
      end else begin
        kind = pick_kind();
        a = pick_address();
        // a burst of back-to-back requests in every fifth block of 64
        add_req(kind, a, $urandom, $urandom, ((made / 64) % 5 == 2) ? 0 : pick_gap());
        made++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent and every reply seen
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || req_if.valid || bus_replies.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: clearing pass plus the worst-case stimulus, several times over
  initial begin
    #5_600_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ssmb_pkg.sv
rtl/core/ssmb_if.sv
rtl/core/ssmb_ram.sv
rtl/core/ssmb_clr.sv
rtl/core/ssmb_io.sv
rtl/core/soft_switch_memory_bus_top.sv
rtl/core/ssmb_chk.sv
sim/soft_switch_memory_bus_top_tb.sv
